/* rtl/pli_pkg.sv */
// Shared constants, codes and types of the positional list block.
`default_nettype none

package pli_pkg;

  // Store geometry.
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int ADDR_W     = $clog2(DEPTH);

  // Fixed field widths.
  localparam int OP_W  = 3;
  localparam int POS_W = 8;
  localparam int ST_W  = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_POS  = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_HEAD = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_TAIL = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_POS  = 3'd5;
  localparam logic [OP_W-1:0] OP_DUMP     = 3'd6;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_DMP_RD,
    S_DMP_OUT,
    S_RESULT
  } state_t;

  // One result item as handed from the sequencer to the output stage.
  typedef struct packed {
    logic [ST_W-1:0]              status;
    logic signed [DATA_WIDTH-1:0] element;
    logic                         element_valid;
    logic                         last;
    logic [CNT_W-1:0]             count;
  } res_t;

endpackage

`default_nettype wire

/* rtl/pli_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/pli_seq.sv */
// Sequencer that shifts list cells one at a time through a shared index stepper.
`default_nettype none

module pli_seq (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // Operation item.
  input  wire logic                                  op_valid,
  output logic                                       op_busy,
  input  wire logic [pli_pkg::OP_W-1:0]              op,
  input  wire logic signed [pli_pkg::DATA_WIDTH-1:0] value,
  input  wire logic [pli_pkg::POS_W-1:0]             position,
  // Store port.
  output logic                                       ram_we,
  output logic [pli_pkg::ADDR_W-1:0]                 ram_waddr,
  output logic [pli_pkg::DATA_WIDTH-1:0]             ram_wdata,
  output logic [pli_pkg::ADDR_W-1:0]                 ram_raddr,
  input  wire logic [pli_pkg::DATA_WIDTH-1:0]        ram_rdata,
  // Result item.
  output logic                                       res_valid,
  input  wire logic                                  res_ready,
  output pli_pkg::res_t                              res
);

  localparam int CW = pli_pkg::CNT_W;
  localparam int PW = pli_pkg::POS_W + 1;

  pli_pkg::state_t              state_r, state_nxt;
  logic [CW-1:0]                len_r, len_nxt;
  logic [CW-1:0]                ptr_r, ptr_nxt;
  logic [CW-1:0]                idx_r, idx_nxt;
  logic [pli_pkg::DATA_WIDTH-1:0] val_r, val_nxt;
  logic [pli_pkg::ST_W-1:0]     status_r, status_nxt;

  logic          accept;
  logic          dec;
  logic [CW-1:0] step;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] len_ext;
  logic          ins_bad;
  logic          del_bad;
  logic [CW-1:0] pos_idx;
  logic          is_full;
  logic          is_empty;
  logic          dmp_last;

  // Decode of the incoming operation against the current length.
  assign accept   = op_valid && (state_r == pli_pkg::S_IDLE);
  assign op_busy  = (state_r != pli_pkg::S_IDLE);
  assign pos_ext  = PW'(position);
  assign len_ext  = PW'(len_r);
  assign ins_bad  = (position == '0) || (pos_ext > len_ext + PW'(1));
  assign del_bad  = (position == '0) || (pos_ext > len_ext);
  assign pos_idx  = CW'(position - pli_pkg::POS_W'(1));
  assign is_full  = (len_r == CW'(pli_pkg::DEPTH));
  assign is_empty = (len_r == '0);

  // The shared index stepper: counts down while opening a gap, up otherwise.
  assign dec  = (state_r == pli_pkg::S_INS_RD) || (state_r == pli_pkg::S_INS_WR);
  assign step = dec ? (ptr_r - CW'(1)) : (ptr_r + CW'(1));
  assign dmp_last = (step == len_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pli_pkg::S_IDLE: begin
        if (op_valid) begin
          case (op)
            pli_pkg::OP_INS_HEAD, pli_pkg::OP_INS_TAIL: begin
              state_nxt = is_full ? pli_pkg::S_RESULT : pli_pkg::S_INS_RD;
            end
            pli_pkg::OP_INS_POS: begin
              state_nxt = (ins_bad || is_full) ? pli_pkg::S_RESULT : pli_pkg::S_INS_RD;
            end
            pli_pkg::OP_DEL_HEAD, pli_pkg::OP_DEL_TAIL: begin
              state_nxt = is_empty ? pli_pkg::S_RESULT : pli_pkg::S_DEL_RD;
            end
            pli_pkg::OP_DEL_POS: begin
              state_nxt = (is_empty || del_bad) ? pli_pkg::S_RESULT : pli_pkg::S_DEL_RD;
            end
            pli_pkg::OP_DUMP: begin
              state_nxt = is_empty ? pli_pkg::S_RESULT : pli_pkg::S_DMP_RD;
            end
            default: begin
              state_nxt = pli_pkg::S_RESULT;
            end
          endcase
        end
      end
      pli_pkg::S_INS_RD: begin
        state_nxt = (ptr_r == idx_r) ? pli_pkg::S_RESULT : pli_pkg::S_INS_WR;
      end
      pli_pkg::S_INS_WR: begin
        state_nxt = pli_pkg::S_INS_RD;
      end
      pli_pkg::S_DEL_RD: begin
        state_nxt = (step == len_r) ? pli_pkg::S_RESULT : pli_pkg::S_DEL_WR;
      end
      pli_pkg::S_DEL_WR: begin
        state_nxt = pli_pkg::S_DEL_RD;
      end
      pli_pkg::S_DMP_RD: begin
        state_nxt = pli_pkg::S_DMP_OUT;
      end
      pli_pkg::S_DMP_OUT: begin
        if (res_ready) begin
          state_nxt = dmp_last ? pli_pkg::S_IDLE : pli_pkg::S_DMP_RD;
        end
      end
      pli_pkg::S_RESULT: begin
        if (res_ready) begin
          state_nxt = pli_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pli_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath updates, store control and result.
  always_comb begin
    len_nxt    = len_r;
    ptr_nxt    = ptr_r;
    idx_nxt    = idx_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    ram_we     = 1'b0;
    ram_waddr  = ptr_r[pli_pkg::ADDR_W-1:0];
    ram_wdata  = ram_rdata;
    ram_raddr  = ptr_r[pli_pkg::ADDR_W-1:0];
    res_valid  = 1'b0;
    res.status        = status_r;
    res.element       = '0;
    res.element_valid = 1'b0;
    res.last          = 1'b1;
    res.count         = len_r;
    case (state_r)
      pli_pkg::S_IDLE: begin
        if (accept) begin
          val_nxt    = value;
          status_nxt = pli_pkg::ST_OK;
          case (op)
            pli_pkg::OP_INS_HEAD, pli_pkg::OP_INS_TAIL, pli_pkg::OP_INS_POS: begin
              ptr_nxt = len_r;
              if (op == pli_pkg::OP_INS_HEAD) begin
                idx_nxt = '0;
              end else if (op == pli_pkg::OP_INS_TAIL) begin
                idx_nxt = len_r;
              end else begin
                idx_nxt = pos_idx;
              end
              if ((op == pli_pkg::OP_INS_POS) && ins_bad) begin
                status_nxt = pli_pkg::ST_BADPOS;
              end else if (is_full) begin
                status_nxt = pli_pkg::ST_FULL;
              end
            end
            pli_pkg::OP_DEL_HEAD, pli_pkg::OP_DEL_TAIL, pli_pkg::OP_DEL_POS: begin
              if (op == pli_pkg::OP_DEL_HEAD) begin
                ptr_nxt = '0;
              end else if (op == pli_pkg::OP_DEL_TAIL) begin
                ptr_nxt = len_r - CW'(1);
              end else begin
                ptr_nxt = pos_idx;
              end
              if (is_empty) begin
                status_nxt = pli_pkg::ST_EMPTY;
              end else if ((op == pli_pkg::OP_DEL_POS) && del_bad) begin
                status_nxt = pli_pkg::ST_BADPOS;
              end
            end
            pli_pkg::OP_DUMP: begin
              ptr_nxt = '0;
              if (is_empty) begin
                status_nxt = pli_pkg::ST_EMPTY;
              end
            end
            default: begin
              status_nxt = pli_pkg::ST_OK;
            end
          endcase
        end
      end
      pli_pkg::S_INS_RD: begin
        // Either drop the new value into the gap or fetch the cell below it.
        ram_raddr = step[pli_pkg::ADDR_W-1:0];
        if (ptr_r == idx_r) begin
          ram_we    = 1'b1;
          ram_wdata = val_r;
          len_nxt   = len_r + CW'(1);
        end
      end
      pli_pkg::S_INS_WR: begin
        // Move the fetched cell up by one place.
        ram_we  = 1'b1;
        ptr_nxt = step;
      end
      pli_pkg::S_DEL_RD: begin
        ram_raddr = step[pli_pkg::ADDR_W-1:0];
        if (step == len_r) begin
          len_nxt = len_r - CW'(1);
        end
      end
      pli_pkg::S_DEL_WR: begin
        // Move the fetched cell down by one place.
        ram_we  = 1'b1;
        ptr_nxt = step;
      end
      pli_pkg::S_DMP_RD: begin
        ram_raddr = ptr_r[pli_pkg::ADDR_W-1:0];
      end
      pli_pkg::S_DMP_OUT: begin
        // The read address stays put so the read data holds while stalled.
        res_valid         = 1'b1;
        res.status        = pli_pkg::ST_OK;
        res.element       = ram_rdata;
        res.element_valid = 1'b1;
        res.last          = dmp_last;
        if (res_ready) begin
          ptr_nxt = step;
        end
      end
      pli_pkg::S_RESULT: begin
        res_valid = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Control state is reset; the captured operands are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pli_pkg::S_IDLE;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    idx_r    <= idx_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
  end

  // The list never grows past the store.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CW'(pli_pkg::DEPTH))
    else $error("list length exceeds the store depth");

  // One operation moves the length by at most one.
  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != $past(len_r)) |->
      ((len_r == $past(len_r) + CW'(1)) || (len_r + CW'(1) == $past(len_r))))
    else $error("length changed by more than one");

  // While opening a gap the pointer stays between the target and the tail.
  a_ins_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pli_pkg::S_INS_RD) |-> ((ptr_r >= idx_r) && (ptr_r <= len_r)))
    else $error("insert pointer left its range");

  // After the final result of an item the sequencer is free again.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready && res.last) |=> (state_r == pli_pkg::S_IDLE))
    else $error("sequencer busy after final result");

endmodule

`default_nettype wire

/* rtl/positional_list_insert_delete.sv */
// Positional list top level: operation sequencer, cell store and output register.
// An insert at 0-based place k shifts each cell from k up one place and writes the value
// into the gap; a delete at k shifts each cell above k down one place; then the result
// is handed over. A refused operation only hands over its result; a dump, one element at a
// time. Results leave via the output register; a new operation is taken only while idle.
// Reset empties the list and clears control; the cell store itself is not cleared.
`default_nettype none

module positional_list_insert_delete (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [pli_pkg::OP_W-1:0]              in_op,
  input  wire logic signed [pli_pkg::DATA_WIDTH-1:0] in_value,
  input  wire logic [pli_pkg::POS_W-1:0]             in_position,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [pli_pkg::ST_W-1:0]                   out_status,
  output logic signed [pli_pkg::DATA_WIDTH-1:0]      out_element,
  output logic                                       out_element_valid,
  output logic                                       out_last,
  output logic [pli_pkg::CNT_W-1:0]                  out_count
);

  logic                           ram_we;
  logic [pli_pkg::ADDR_W-1:0]     ram_waddr;
  logic [pli_pkg::DATA_WIDTH-1:0] ram_wdata;
  logic [pli_pkg::ADDR_W-1:0]     ram_raddr;
  logic [pli_pkg::DATA_WIDTH-1:0] ram_rdata;
  logic                           res_valid;
  logic                           res_ready;
  pli_pkg::res_t                  res;
  logic                           out_valid_r, out_valid_nxt;
  pli_pkg::res_t                  out_r;

  // Operation sequencer.
  pli_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (in_valid),
    .op_busy   (in_stall),
    .op        (in_op),
    .value     (in_value),
    .position  (in_position),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Cell store.
  pli_ram #(
    .WIDTH (pli_pkg::DATA_WIDTH),
    .DEPTH (pli_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: takes a new item when empty or when its item leaves.
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_element       = out_r.element;
  assign out_element_valid = out_r.element_valid;
  assign out_last          = out_r.last;
  assign out_count         = out_r.count;

endmodule

`default_nettype wire
